[rtl/core/aoc_pkg.sv]
// Alpha-over compositor package: pixel payload types, pipeline stage records
// and fixed widths shared by the interfaces and every core module.
// No dependencies.
`default_nettype none

package aoc_pkg;

    localparam int CH_W        = 8;
    localparam int NUM_CH      = 3;
    localparam int W_W         = 16;   // compositing weight, max 255*256
    localparam int N_W         = 24;   // weighted channel sum, below w*256
    localparam int DIV_STEP    = 2;    // quotient bits resolved per divider stage
    localparam int DIV_STAGES  = CH_W / DIV_STEP;

    localparam logic [CH_W-1:0] FULL_ALPHA  = 8'hFF;
    localparam logic [W_W-1:0]  UNIT_WEIGHT = 16'h0100;
    localparam int              FRAC_BITS   = 8;

    typedef struct packed {
        logic [CH_W-1:0] dst_red;
        logic [CH_W-1:0] dst_green;
        logic [CH_W-1:0] dst_blue;
        logic [CH_W-1:0] dst_alpha;
        logic [CH_W-1:0] src_red;
        logic [CH_W-1:0] src_green;
        logic [CH_W-1:0] src_blue;
        logic [CH_W-1:0] src_alpha;
    } t_in_pix;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
    } t_out_pix;

    // weights chosen so that every case reduces to (ws*s + wd*d) / w
    typedef struct packed {
        logic [W_W-1:0]               ws;
        logic [W_W-1:0]               wd;
        logic [W_W-1:0]               w;
        logic [CH_W-1:0]              alpha;
        logic [NUM_CH-1:0][CH_W-1:0]  src;
        logic [NUM_CH-1:0][CH_W-1:0]  dst;
    } t_prep_stage;

    typedef struct packed {
        logic [NUM_CH-1:0][N_W-1:0]   num;
        logic [W_W-1:0]               w;
        logic [CH_W-1:0]              alpha;
    } t_mul_stage;

    typedef struct packed {
        logic [NUM_CH-1:0][N_W-1:0]   rem;
        logic [NUM_CH-1:0][CH_W-1:0]  quo;
        logic [W_W-1:0]               w;
        logic [CH_W-1:0]              alpha;
    } t_div_stage;

endpackage

`default_nettype wire

[rtl/core/aoc_if.sv]
// Valid/ready channel interfaces for the compositor pixel streams.
// Depends on aoc_pkg for the payload types.
`default_nettype none

interface aoc_pix_in_if;
    import aoc_pkg::*;

    logic    valid;
    logic    ready;
    t_in_pix data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface aoc_pix_out_if;
    import aoc_pkg::*;

    logic     valid;
    logic     ready;
    t_out_pix data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/aoc_prep.sv]
// First pipeline stage: classifies the pixel pair and derives the blend
// weights and result alpha. Depends on aoc_pkg.
`default_nettype none

module aoc_prep (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_vld,
    input  aoc_pkg::t_in_pix     i_pix,
    output logic                 o_vld,
    output aoc_pkg::t_prep_stage o_stage
);
    import aoc_pkg::*;

    logic [CH_W-1:0] sa;
    logic [CH_W-1:0] da;
    logic [W_W-1:0]  ws_gen;
    logic [W_W-1:0]  wd_gen;
    logic [W_W-1:0]  w_gen;
    t_prep_stage     n_stage;
    t_prep_stage     r_stage;
    logic            r_vld;

    assign sa     = i_pix.src_alpha;
    assign da     = i_pix.dst_alpha;
    assign ws_gen = {sa, 8'h00};
    assign wd_gen = {8'h00, FULL_ALPHA - sa} * {8'h00, da};
    assign w_gen  = ws_gen + wd_gen;

    always_comb begin
        n_stage.src = {i_pix.src_blue, i_pix.src_green, i_pix.src_red};
        n_stage.dst = {i_pix.dst_blue, i_pix.dst_green, i_pix.dst_red};
        if (sa == FULL_ALPHA) begin
            // quotient of s*1/1 passes the source through
            n_stage.ws    = W_W'(1);
            n_stage.wd    = '0;
            n_stage.w     = W_W'(1);
            n_stage.alpha = FULL_ALPHA;
        end else if (da == FULL_ALPHA) begin
            // divide by 256 is the >>8 of the opaque-destination blend
            n_stage.ws    = {8'h00, sa};
            n_stage.wd    = UNIT_WEIGHT - {8'h00, sa};
            n_stage.w     = UNIT_WEIGHT;
            n_stage.alpha = FULL_ALPHA;
        end else if (w_gen[W_W-1:FRAC_BITS] == '0) begin
            // negligible coverage: zero numerator gives an all-zero pixel
            n_stage.ws    = '0;
            n_stage.wd    = '0;
            n_stage.w     = W_W'(1);
            n_stage.alpha = '0;
        end else begin
            n_stage.ws    = ws_gen;
            n_stage.wd    = wd_gen;
            n_stage.w     = w_gen;
            n_stage.alpha = w_gen[W_W-1:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_vld   = r_vld;
    assign o_stage = r_stage;

endmodule

`default_nettype wire

[rtl/core/aoc_mul.sv]
// Second pipeline stage: forms the weighted channel sums ws*s + wd*d for
// the three color channels. Depends on aoc_pkg.
`default_nettype none

module aoc_mul (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_vld,
    input  aoc_pkg::t_prep_stage i_stage,
    output logic                 o_vld,
    output aoc_pkg::t_mul_stage  o_stage
);
    import aoc_pkg::*;

    t_mul_stage n_stage;
    t_mul_stage r_stage;
    logic       r_vld;

    always_comb begin
        n_stage.w     = i_stage.w;
        n_stage.alpha = i_stage.alpha;
        for (int c = 0; c < NUM_CH; c++) begin
            n_stage.num[c] = {8'h00, i_stage.ws} * {16'h0000, i_stage.src[c]}
                           + {8'h00, i_stage.wd} * {16'h0000, i_stage.dst[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_vld   = r_vld;
    assign o_stage = r_stage;

endmodule

`default_nettype wire

[rtl/core/aoc_div.sv]
// Pipelined restoring divider: resolves two quotient bits per register
// stage, three channels in parallel against the shared weight.
// Depends on aoc_pkg.
`default_nettype none

module aoc_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_vld,
    input  aoc_pkg::t_mul_stage i_stage,
    output logic                o_vld,
    output aoc_pkg::t_out_pix   o_pix
);
    import aoc_pkg::*;

    t_div_stage n_stage [DIV_STAGES];
    t_div_stage r_stage [DIV_STAGES];
    logic [DIV_STAGES-1:0] r_vld;

    // quotient is known to fit in 8 bits, so the walk starts at bit 7
    always_comb begin
        t_div_stage cur;
        logic [N_W-1:0] dsr;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                cur.rem   = i_stage.num;
                cur.quo   = '0;
                cur.w     = i_stage.w;
                cur.alpha = i_stage.alpha;
            end else begin
                cur = r_stage[k-1];
            end
            for (int j = 0; j < DIV_STEP; j++) begin
                dsr = {8'h00, cur.w} << (CH_W - 1 - k * DIV_STEP - j);
                for (int c = 0; c < NUM_CH; c++) begin
                    if (cur.rem[c] >= dsr) begin
                        cur.rem[c] = cur.rem[c] - dsr;
                        cur.quo[c] = {cur.quo[c][CH_W-2:0], 1'b1};
                    end else begin
                        cur.quo[c] = {cur.quo[c][CH_W-2:0], 1'b0};
                    end
                end
            end
            n_stage[k] = cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_stage[k] <= n_stage[k];
            end
        end
    end

    assign o_vld           = r_vld[DIV_STAGES-1];
    assign o_pix.out_red   = r_stage[DIV_STAGES-1].quo[0];
    assign o_pix.out_green = r_stage[DIV_STAGES-1].quo[1];
    assign o_pix.out_blue  = r_stage[DIV_STAGES-1].quo[2];
    assign o_pix.out_alpha = r_stage[DIV_STAGES-1].alpha;

endmodule

`default_nettype wire

[rtl/core/alpha_over_compositor_core.sv]
// Source-over compositor for RGBA8 pixel pairs. Takes one pixel pair per
// clock and returns one composited pixel per pair, in order, from a pipeline
// in which one stage forms the blend weights and result alpha, one forms
// the weighted channel sums, and four stages of a restoring divider (two
// quotient bits each) divide those sums by the total weight.
// The whole pipeline advances together; it holds when the last stage has
// a pixel that the sink has not taken, so i_pix.ready follows o_res.ready
// in that case. Depends on aoc_pkg and the interfaces in aoc_if.sv.
`default_nettype none

module alpha_over_compositor_core (
    input  wire           i_clk,
    input  wire           i_rst_n,
    aoc_pix_in_if.sink    i_pix,
    aoc_pix_out_if.source o_res
);
    import aoc_pkg::*;

    logic        adv;
    logic        prep_vld;
    t_prep_stage prep_stage;
    logic        mul_vld;
    t_mul_stage  mul_stage;
    logic        div_vld;
    t_out_pix    div_pix;

    assign adv         = !div_vld || o_res.ready;
    assign i_pix.ready = adv;

    aoc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (i_pix.valid),
        .i_pix   (i_pix.data),
        .o_vld   (prep_vld),
        .o_stage (prep_stage)
    );

    aoc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (prep_vld),
        .i_stage (prep_stage),
        .o_vld   (mul_vld),
        .o_stage (mul_stage)
    );

    aoc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (mul_vld),
        .i_stage (mul_stage),
        .o_vld   (div_vld),
        .o_pix   (div_pix)
    );

    assign o_res.valid = div_vld;
    assign o_res.data  = div_pix;

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for alpha_over_compositor_core: random and directed
// pixel pairs with random stalls on both channels, checked against a predictor.
// Depends on aoc_pkg and the stream interfaces in aoc_if.sv.

module testbench;
    import aoc_pkg::*;

    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_PAIRS  = 550;
    localparam int DRAIN_CYCLES  = 12;
    localparam int REPORT_MAX    = 10;

    // Holds the composited pixels still owed by the block, oldest first.
    class composite_checker;
        t_out_pix    owed_pixels[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned opaque_src_n;
        int unsigned opaque_dst_n;
        int unsigned blend_n;
        int unsigned negligible_n;

        function logic [CH_W-1:0] blend_onto_opaque(int unsigned sa, int unsigned s,
                                                     int unsigned d);
            return CH_W'((sa * s + (int'(UNIT_WEIGHT) - sa) * d) >> FRAC_BITS);
        endfunction

        function logic [CH_W-1:0] weighted_mean(int unsigned ws, int unsigned wd,
                                                int unsigned w, int unsigned s,
                                                int unsigned d);
            return CH_W'((ws * s + wd * d) / w);
        endfunction

        function t_out_pix composite_over(t_in_pix p);
            int unsigned sa;
            int unsigned da;
            int unsigned ws;
            int unsigned wd;
            int unsigned w;
            t_out_pix    r;
            sa = p.src_alpha;
            da = p.dst_alpha;
            r  = '0;
            if (sa == FULL_ALPHA) begin
                opaque_src_n++;
                r.out_red   = p.src_red;
                r.out_green = p.src_green;
                r.out_blue  = p.src_blue;
                r.out_alpha = p.src_alpha;
            end else if (da == FULL_ALPHA) begin
                opaque_dst_n++;
                r.out_red   = blend_onto_opaque(sa, p.src_red, p.dst_red);
                r.out_green = blend_onto_opaque(sa, p.src_green, p.dst_green);
                r.out_blue  = blend_onto_opaque(sa, p.src_blue, p.dst_blue);
                r.out_alpha = FULL_ALPHA;
            end else begin
                ws = sa << FRAC_BITS;
                wd = (int'(FULL_ALPHA) - sa) * da;
                w  = ws + wd;
                if ((w >> FRAC_BITS) == 0) begin
                    // coverage too small to show: everything zero
                    negligible_n++;
                end else begin
                    blend_n++;
                    r.out_red   = weighted_mean(ws, wd, w, p.src_red, p.dst_red);
                    r.out_green = weighted_mean(ws, wd, w, p.src_green, p.dst_green);
                    r.out_blue  = weighted_mean(ws, wd, w, p.src_blue, p.dst_blue);
                    r.out_alpha = CH_W'(w >> FRAC_BITS);
                end
            end
            return r;
        endfunction

        function void note_pair(t_in_pix p);
            owed_pixels.push_back(composite_over(p));
        endfunction

        function void check_pixel(t_out_pix got);
            t_out_pix want;
            checked++;
            if (owed_pixels.size() == 0) begin
                if (mismatches < REPORT_MAX)
                    $display("ERROR: unexpected result pixel %h", got);
                mismatches++;
                return;
            end
            want = owed_pixels.pop_front();
            if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
                got.out_blue !== want.out_blue || got.out_alpha !== want.out_alpha) begin
                if (mismatches < REPORT_MAX)
                    $display("ERROR: pixel %0d rgba exp %h %h %h %h got %h %h %h %h",
                             checked, want.out_red, want.out_green, want.out_blue,
                             want.out_alpha, got.out_red, got.out_green, got.out_blue,
                             got.out_alpha);
                mismatches++;
            end
        endfunction

        function int pending();
            return owed_pixels.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;
    int   stall_cycles;
    int   pairs_sent;

    composite_checker sb;

    aoc_pix_in_if  pix_in ();
    aoc_pix_out_if pix_out ();

    alpha_over_compositor_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_res   (pix_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        pix_out.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // monitor and stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pix_in.valid && pix_in.ready)
                sb.note_pair(pix_in.data);
            if (pix_out.valid && pix_out.ready)
                sb.check_pixel(pix_out.data);
            if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
                $display("FAIL alpha_over_compositor_core");
                $finish;
            end
        end
    end

    function t_in_pix make_pair(logic [7:0] dr, logic [7:0] dg, logic [7:0] db,
                                logic [7:0] da, logic [7:0] sr, logic [7:0] sg,
                                logic [7:0] sbl, logic [7:0] sa);
        t_in_pix p;
        p.dst_red   = dr;
        p.dst_green = dg;
        p.dst_blue  = db;
        p.dst_alpha = da;
        p.src_red   = sr;
        p.src_green = sg;
        p.src_blue  = sbl;
        p.src_alpha = sa;
        return p;
    endfunction

    function logic [CH_W-1:0] rand_channel();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return '1;
        return CH_W'($urandom_range(0, 255));
    endfunction

    // alpha mix weighted toward the opaque and near-transparent corners
    function t_in_pix random_pair();
        t_in_pix p;
        int      sel;
        p = make_pair(rand_channel(), rand_channel(), rand_channel(), rand_channel(),
                      rand_channel(), rand_channel(), rand_channel(), rand_channel());
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
            p.src_alpha = FULL_ALPHA;
        end else if (sel < 40) begin
            p.dst_alpha = FULL_ALPHA;
            p.src_alpha = CH_W'($urandom_range(0, 254));
        end else if (sel < 55) begin
            p.src_alpha = CH_W'($urandom_range(0, 3));
            p.dst_alpha = CH_W'($urandom_range(0, 3));
        end else if (sel < 70) begin
            p.src_alpha = CH_W'($urandom_range(0, 254));
            p.dst_alpha = CH_W'($urandom_range(0, 254));
        end
        return p;
    endfunction

    task automatic send_pixel(t_in_pix p);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            pix_in.valid <= 1'b0;
            pix_in.data  <= t_in_pix'({$urandom, $urandom});
            @(negedge i_clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.data  <= p;
        do @(posedge i_clk); while (!pix_in.ready);
        pairs_sent++;
        @(negedge i_clk);
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        pix_in.valid  = 1'b0;
        pix_in.data   = '0;
        pix_out.ready = 1'b0;
        src_idle_pct  = 9;
        sink_idle_pct = 49;
        stall_cycles  = 0;
        pairs_sent    = 0;
        sb            = new();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // field extremes, opaque source and destination, negligible coverage
        send_pixel(make_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_pixel(make_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pair(8'h12, 8'h34, 8'h56, 8'h00, 8'hAB, 8'hCD, 8'hEF, 8'hFF));
        send_pixel(make_pair(8'hFF, 8'h00, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'h00, 8'hFF));
        send_pixel(make_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
        send_pixel(make_pair(8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'h01));
        send_pixel(make_pair(8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'hFE));
        send_pixel(make_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80));
        send_pixel(make_pair(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00));
        send_pixel(make_pair(8'hFF, 8'hFF, 8'hFF, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h00));
        send_pixel(make_pair(8'hFF, 8'hFF, 8'hFF, 8'h02, 8'hFF, 8'hFF, 8'hFF, 8'h00));
        send_pixel(make_pair(8'hFF, 8'h00, 8'h7F, 8'h00, 8'h00, 8'hFF, 8'h80, 8'h01));
        send_pixel(make_pair(8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'h00, 8'h00, 8'h00, 8'hFE));
        send_pixel(make_pair(8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFE));
        send_pixel(make_pair(8'h00, 8'h00, 8'h00, 8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'h01));
        send_pixel(make_pair(8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h00, 8'hFE));
        send_pixel(make_pair(8'h55, 8'hAA, 8'h55, 8'h80, 8'hAA, 8'h55, 8'hAA, 8'h80));
        send_pixel(make_pair(8'hAA, 8'h55, 8'hAA, 8'h7F, 8'h55, 8'hAA, 8'h55, 8'h7F));

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 9;
                    sink_idle_pct = 49;
                end
                1: begin
                    src_idle_pct  = 49;
                    sink_idle_pct = 9;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < RANDOM_PAIRS / 3; n++)
                send_pixel(random_pair());
        end
        pix_in.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d pixel pairs, checked %0d results, %0d mismatches",
                 pairs_sent, sb.checked, sb.mismatches);
        $display("Cases: %0d opaque source, %0d opaque destination, %0d blended, %0d negligible",
                 sb.opaque_src_n, sb.opaque_dst_n, sb.blend_n, sb.negligible_n);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS alpha_over_compositor_core");
        else
            $display("FAIL alpha_over_compositor_core");
        $finish;
    end

endmodule

[alpha_over_compositor_core.f]
rtl/core/aoc_pkg.sv
rtl/core/aoc_if.sv
rtl/core/aoc_prep.sv
rtl/core/aoc_mul.sv
rtl/core/aoc_div.sv
rtl/core/alpha_over_compositor_core.sv
tb/testbench.sv
